// File: rtl/core/shct_pkg.sv
// shared types, codes and constants of the stick hold calibration trigger
package shct_pkg;

	// fixed field widths
	localparam int STICK_BITS    = 12;
	localparam int THR_BITS      = 11;
	localparam int TOL_BITS      = 8;
	localparam int TICK_BITS     = 16;
	localparam int PHASE_BITS    = 3;
	localparam int REQ_BITS      = 2;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	// default counter width
	localparam int COUNTER_BITS_DEF = 16;

	// compare width that holds sticks, magnitudes and thresholds with sign
	localparam int CMP_BITS = ((STICK_BITS > THR_BITS) ? STICK_BITS : THR_BITS) + 2;

	// register reset values
	localparam logic [THR_BITS-1:0]  ARM_THRESHOLD_RST   = THR_BITS'(300);
	localparam logic [TOL_BITS-1:0]  STILL_TOLERANCE_RST = TOL_BITS'(2);
	localparam logic [TICK_BITS-1:0] HOLD_TICKS_RST      = TICK_BITS'(5000);
	localparam logic [TICK_BITS-1:0] CONFIRM_TICKS_RST   = TICK_BITS'(100);

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_ARM_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_STILL_TOLERANCE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TICKS      = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CONFIRM_TICKS   = 2'd3;

	// phase codes
	localparam logic [PHASE_BITS-1:0] PH_IDLE        = 3'd0;
	localparam logic [PHASE_BITS-1:0] PH_ACC_ARM     = 3'd1;
	localparam logic [PHASE_BITS-1:0] PH_GYRO_ARM    = 3'd2;
	localparam logic [PHASE_BITS-1:0] PH_ACC_CONFIRM = 3'd3;
	localparam logic [PHASE_BITS-1:0] PH_GYRO_WAIT   = 3'd4;
	localparam logic [PHASE_BITS-1:0] PH_ACC_WAIT    = 3'd5;

	// armed phase to request phase offset
	localparam logic [PHASE_BITS-1:0] PH_ARM_STEP    = 3'd2;

	// request codes
	localparam logic [REQ_BITS-1:0] REQ_NONE        = 2'd0;
	localparam logic [REQ_BITS-1:0] REQ_GYRO        = 2'd1;
	localparam logic [REQ_BITS-1:0] REQ_ACC         = 2'd2;
	localparam logic [REQ_BITS-1:0] REQ_ACC_CONFIRM = 2'd3;

	// input word
	typedef struct packed {
		logic signed [STICK_BITS-1:0] stick_x;
		logic signed [STICK_BITS-1:0] stick_y;
		logic                         calib_busy;
	} stick_word_t;

	// result word
	typedef struct packed {
		logic [PHASE_BITS-1:0] phase;
		logic [REQ_BITS-1:0]   calib_request;
		logic                  clear_setpoints;
	} result_word_t;

	// configuration register set
	typedef struct packed {
		logic [THR_BITS-1:0]  arm_threshold;
		logic [TOL_BITS-1:0]  still_tolerance;
		logic [TICK_BITS-1:0] hold_ticks;
		logic [TICK_BITS-1:0] confirm_ticks;
	} cfg_t;

endpackage

// File: rtl/core/stick_hold_calibration_trigger_top.sv
// top level of the stick hold calibration trigger
// One stick word per clock is accepted and one result word comes out for each. A word
// sits in the input register until the result register is free, and the gesture state is
// updated in a single step as it moves into the result register, which holds its result
// valid until it is taken.
// Throughput is one word per clock; it only drops when the result side stalls, and the
// input register then holds one more word. An accelerometer request issued on the tick
// the sticks are released leaves the phase at gyro arm.
// Configuration registers reset to threshold 300, tolerance 2, hold 5000 and confirm 100
// ticks and should be written only while no word is in flight.
module stick_hold_calibration_trigger_top
	import shct_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     stick_valid,
	output logic                     stick_ready,
	input  stick_word_t              stick,
	output logic                     result_valid,
	input  logic                     result_ready,
	output result_word_t             result,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t         cfg;
	stick_word_t  word_s1;
	logic         valid_s1;
	logic         advance;
	result_word_t next_result;
	result_word_t result_q;
	logic         result_valid_q;

	// handshake between input and result registers
	assign advance     = valid_s1 && (!result_valid_q || result_ready);
	assign stick_ready = !valid_s1 || advance;

	shct_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stick_ready) begin
			valid_s1 <= stick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stick_ready && stick_valid) begin
			word_s1 <= stick;
		end
	end

	shct_core #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.word   (word_s1),
		.cfg    (cfg),
		.result (next_result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= next_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTH
	// a gyro request always lands in gyro wait
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.calib_request == REQ_GYRO |-> result_q.phase == PH_GYRO_WAIT)
		else $error("gyro request without gyro wait phase");

	// an accelerometer request lands in acc confirm, or in gyro arm when issued on release
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.calib_request == REQ_ACC |->
			result_q.phase == PH_ACC_CONFIRM || result_q.phase == PH_GYRO_ARM)
		else $error("accelerometer request without confirm phase");

	// clearing only happens from the wait phases, which lead to wait or idle
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.clear_setpoints |->
			result_q.phase == PH_IDLE || result_q.phase == PH_GYRO_WAIT ||
			result_q.phase == PH_ACC_WAIT)
		else $error("set point clear outside wait phases");

	// a word held in the input register is neither lost nor changed
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(word_s1))
		else $error("stalled input word dropped or changed");
`endif

endmodule

// File: rtl/core/shct_cfg.sv
// configuration registers of the stick hold calibration trigger
module shct_cfg
	import shct_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	// register writes by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arm_threshold   <= ARM_THRESHOLD_RST;
			cfg_q.still_tolerance <= STILL_TOLERANCE_RST;
			cfg_q.hold_ticks      <= HOLD_TICKS_RST;
			cfg_q.confirm_ticks   <= CONFIRM_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ARM_THRESHOLD:   cfg_q.arm_threshold   <= cfg_data[THR_BITS-1:0];
				REG_STILL_TOLERANCE: cfg_q.still_tolerance <= cfg_data[TOL_BITS-1:0];
				REG_HOLD_TICKS:      cfg_q.hold_ticks      <= cfg_data[TICK_BITS-1:0];
				REG_CONFIRM_TICKS:   cfg_q.confirm_ticks   <= cfg_data[TICK_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/shct_core.sv
// gesture state and single-step update of the stick hold calibration trigger
module shct_core
	import shct_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  stick_word_t  word,
	input  cfg_t         cfg,
	output result_word_t result
);

	localparam int CNT_CMP_BITS = (COUNTER_BITS > TICK_BITS) ? COUNTER_BITS : TICK_BITS;

	logic [PHASE_BITS-1:0]   phase_q, phase_d, phase_mid;
	logic [COUNTER_BITS-1:0] cnt_q, cnt_d, cnt_mid, cnt_inc;
	logic [STICK_BITS-1:0]   prev_mag_x_q, prev_mag_y_q;
	logic [STICK_BITS-1:0]   mag_x, mag_y, dmag_x, dmag_y;
	logic signed [STICK_BITS:0] neg_x, neg_y, diff_x, diff_y;
	logic signed [CMP_BITS-1:0] sx_w, sy_w, thr_w, mx_w, my_w, tol_w, dx_w, dy_w;
	logic [CNT_CMP_BITS-1:0] cnt_mid_w, cnt_inc_w, hold_w, confirm_w;
	logic                    pos_arm, neg_arm, released, still, y_high;
	logic [REQ_BITS-1:0]     req;
	logic                    clr;

	// stick magnitudes
	assign neg_x = -(STICK_BITS+1)'(word.stick_x);
	assign neg_y = -(STICK_BITS+1)'(word.stick_y);
	assign mag_x = word.stick_x[STICK_BITS-1] ? neg_x[STICK_BITS-1:0] : word.stick_x;
	assign mag_y = word.stick_y[STICK_BITS-1] ? neg_y[STICK_BITS-1:0] : word.stick_y;

	// magnitude change since last word
	assign diff_x = $signed({1'b0, mag_x}) - $signed({1'b0, prev_mag_x_q});
	assign diff_y = $signed({1'b0, mag_y}) - $signed({1'b0, prev_mag_y_q});
	assign dmag_x = diff_x[STICK_BITS] ? STICK_BITS'(-diff_x) : diff_x[STICK_BITS-1:0];
	assign dmag_y = diff_y[STICK_BITS] ? STICK_BITS'(-diff_y) : diff_y[STICK_BITS-1:0];

	// widened operands for signed compares
	assign sx_w  = CMP_BITS'(word.stick_x);
	assign sy_w  = CMP_BITS'(word.stick_y);
	assign thr_w = $signed(CMP_BITS'(cfg.arm_threshold));
	assign mx_w  = $signed(CMP_BITS'(mag_x));
	assign my_w  = $signed(CMP_BITS'(mag_y));
	assign tol_w = $signed(CMP_BITS'(cfg.still_tolerance));
	assign dx_w  = $signed(CMP_BITS'(dmag_x));
	assign dy_w  = $signed(CMP_BITS'(dmag_y));

	assign pos_arm  = (sx_w >= thr_w) && (sy_w >= thr_w);
	assign neg_arm  = (sx_w <= -thr_w) && (sy_w <= -thr_w);
	assign released = (mx_w <= thr_w) || (my_w <= thr_w);
	assign still    = (dx_w <= tol_w) && (dy_w <= tol_w);
	assign y_high   = (sy_w >= thr_w);

	// hold count after release and stillness checks
	assign cnt_inc   = cnt_q + COUNTER_BITS'(1);
	assign cnt_mid   = still ? (released ? COUNTER_BITS'(1) : cnt_inc) : '0;
	assign phase_mid = released ? PH_IDLE : phase_q;
	assign cnt_mid_w = CNT_CMP_BITS'(cnt_mid);
	assign cnt_inc_w = CNT_CMP_BITS'(cnt_inc);
	assign hold_w    = CNT_CMP_BITS'(cfg.hold_ticks);
	assign confirm_w = CNT_CMP_BITS'(cfg.confirm_ticks);

	// next phase, counter and result
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		req     = REQ_NONE;
		clr     = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (pos_arm) phase_d = PH_GYRO_ARM;
				if (neg_arm) phase_d = PH_ACC_ARM;
				cnt_d = '0;
			end
			PH_ACC_ARM, PH_GYRO_ARM: begin
				if (cnt_mid_w >= hold_w) begin
					cnt_d   = '0;
					req     = (phase_mid == PH_GYRO_ARM) ? REQ_GYRO : REQ_ACC;
					phase_d = phase_mid + PH_ARM_STEP;
				end else begin
					cnt_d   = cnt_mid;
					phase_d = phase_mid;
				end
			end
			PH_ACC_CONFIRM: begin
				if (y_high) begin
					cnt_d = cnt_inc;
					if (cnt_inc_w >= confirm_w) begin
						req     = REQ_ACC_CONFIRM;
						phase_d = PH_ACC_WAIT;
					end
				end else begin
					cnt_d = '0;
				end
			end
			PH_GYRO_WAIT, PH_ACC_WAIT: begin
				clr = 1'b1;
				if (!word.calib_busy) phase_d = PH_IDLE;
			end
			default: ;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			cnt_q        <= '0;
			prev_mag_x_q <= '0;
			prev_mag_y_q <= '0;
		end else if (step) begin
			phase_q      <= phase_d;
			cnt_q        <= cnt_d;
			prev_mag_x_q <= mag_x;
			prev_mag_y_q <= mag_y;
		end
	end

	assign result.phase           = phase_d;
	assign result.calib_request   = req;
	assign result.clear_setpoints = clr;

endmodule
